// File: hdl/gjr_garch_variance_filter_assert.svh
// Assertion macros for the variance filter back end
`ifndef GJR_GARCH_VARIANCE_FILTER_ASSERT_SVH
`define GJR_GARCH_VARIANCE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GJR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GJR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GJR_ASSERT(lbl, prop, msg)
`define GJR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/gjr_pkg.sv
// Shared types and constants for the GJR-GARCH variance filter
`timescale 1ns / 1ps
`default_nettype none
package gjr_pkg;
  localparam int RET_W = 32;
  localparam int VAR_W = 48;
  localparam int COEF_W = 32;
  localparam int TERM_W = 40;
  localparam int SUM_W = 48;
  localparam int DIV_NW = 72;
  localparam int DIV_DW = 48;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [15:0] HALF_LN_2PI_Q16 = 16'd60224;

  localparam logic [2:0] REG_MEAN  = 3'd0;
  localparam logic [2:0] REG_OMEGA = 3'd1;
  localparam logic [2:0] REG_ALPHA = 3'd2;
  localparam logic [2:0] REG_GAMMA = 3'd3;
  localparam logic [2:0] REG_BETA  = 3'd4;
  localparam logic [2:0] REG_INIT  = 3'd5;

  typedef struct packed {
    logic [VAR_W-1:0]  omega;
    logic [COEF_W-1:0] alpha;
    logic [COEF_W-1:0] gamma;
    logic [COEF_W-1:0] beta;
    logic [VAR_W-1:0]  init_var;
    logic              invalid;
  } cfg_t;

  typedef struct packed {
    logic signed [RET_W:0] e;
    logic                  start;
  } item_t;
endpackage
`default_nettype wire

// File: hdl/gjr_front.sv
// Front end: demean each sample and queue it for the back end
`timescale 1ns / 1ps
`default_nettype none
module gjr_front
  import gjr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic signed [RET_W-1:0] return_sample,
  input  wire logic                    start_series,
  input  wire logic signed [RET_W-1:0] mean,
  output logic                         q_valid,
  output item_t                        q_item,
  input  wire logic                    q_take
);
  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wptr].e     <= {return_sample[RET_W-1], return_sample} - {mean[RET_W-1], mean};
      mem[wptr].start <= start_series;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) wptr <= ~wptr;
      if (q_take) rptr <= ~rptr;
      count <= count + {1'b0, accept} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

// File: hdl/gjr_divider.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gjr_divider
  import gjr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic [DIV_NW-1:0]      quot
);
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] dreg;
  logic [6:0]        cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem[DIV_DW-1:0], quot[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem  <= fits ? trial - {1'b0, dreg} : trial;
      quot <= {quot[DIV_NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 7'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/gjr_back.sv
// Back end: variance recursion, log, root and division sequencer
`timescale 1ns / 1ps
`default_nettype none
module gjr_back
  import gjr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cfg_t                     cfg,
  input  wire logic                     q_valid,
  input  wire item_t                    q_item,
  output logic                          q_take,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [VAR_W-1:0]              cond_variance,
  output logic signed [31:0]            std_residual,
  output logic signed [TERM_W-1:0]      ll_term,
  output logic signed [SUM_W-1:0]       ll_sum,
  output logic                          params_invalid
);
  `include "gjr_garch_variance_filter_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_NORM, S_LOG, S_SCALE, S_ROOT, S_DIVQ, S_DIVB, S_MAC, S_DONE
  } state_t;

  state_t               state;
  logic                 out_valid;
  logic [VAR_W-1:0]     var_reg;
  logic signed [SUM_W-1:0] acc;
  logic [VAR_W-1:0]     h;
  logic                 neg;
  logic [RET_W-1:0]     ae;
  logic [63:0]          e2;
  logic [VAR_W-1:0]     norm;
  logic [5:0]           ncnt;
  logic [31:0]          x;
  logic [23:0]          frac;
  logic [4:0]           lcnt;
  logic signed [63:0]   p;
  logic [63:0]          rad;
  logic [34:0]          rr;
  logic [31:0]          root;
  logic [4:0]           rcnt;
  logic [DIV_NW-1:0]    qmag;
  logic [VAR_W-1:0]     bval;
  logic [2:0]           mcnt;
  logic [63:0]          prod;
  logic                 pshift;
  logic                 pvalid;
  logic [59:0]          macc;
  logic                 div_go;
  logic [DIV_NW-1:0]    div_n;
  logic [DIV_DW-1:0]    div_d;
  logic                 div_done;
  logic [DIV_NW-1:0]    div_q;

  // combinational helpers
  logic [VAR_W-1:0]     h_new;
  logic [63:0]          sqx;
  logic [34:0]          rr_sh;
  logic [34:0]          rtrial;
  logic [31:0]          root_nx;
  logic [34:0]          rr_nx;
  logic signed [6:0]    nm40;
  logic signed [30:0]   lval;
  logic [55:0]          e40;
  logic [31:0]          op_a;
  logic [31:0]          op_b;
  logic [63:0]          pmag;
  logic signed [22:0]   aval;
  logic signed [50:0]   term_raw;
  logic signed [TERM_W-1:0] term_sat;
  logic signed [50:0]   sum_raw;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [31:0]   res;

  gjr_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_n),
    .den  (div_d),
    .done (div_done),
    .quot (div_q)
  );

  assign q_take = (state == S_IDLE) && q_valid;
  assign empty  = !out_valid;

  always_comb begin
    h_new = q_item.start ? cfg.init_var : var_reg;
    if (h_new == '0) h_new = VAR_W'(1);
    sqx    = x * x;
    rr_sh  = {rr[32:0], rad[63:62]};
    rtrial = {1'b0, root, 2'b01};
    if (rr_sh >= rtrial) begin
      rr_nx   = rr_sh - rtrial;
      root_nx = {root[30:0], 1'b1};
    end else begin
      rr_nx   = rr_sh;
      root_nx = {root[30:0], 1'b0};
    end
    nm40 = 7'sd7 - $signed({1'b0, ncnt});
    lval = {nm40, frac};
    e40  = e2[63:8];
    case (mcnt)
      3'd0: begin op_a = {8'd0, e40[55:32]};   op_b = cfg.alpha; end
      3'd1: begin op_a = e40[31:0];            op_b = cfg.alpha; end
      3'd2: begin op_a = {8'd0, e40[55:32]};   op_b = neg ? cfg.gamma : '0; end
      3'd3: begin op_a = e40[31:0];            op_b = neg ? cfg.gamma : '0; end
      3'd4: begin op_a = {16'd0, h[47:32]};    op_b = cfg.beta; end
      default: begin op_a = h[31:0];          op_b = cfg.beta; end
    endcase
    pmag = p[63] ? 64'(-p) : 64'(p);
    aval = p[63] ? -$signed({1'b0, pmag[62:41]}) : $signed({1'b0, pmag[62:41]});
    term_raw = -($signed(51'(HALF_LN_2PI_Q16)) + 51'(aval) + $signed({3'd0, bval}));
    if (term_raw > $signed(51'((64'd1 << (TERM_W-1)) - 64'd1)))
      term_sat = {1'b0, {(TERM_W-1){1'b1}}};
    else if (term_raw < -$signed(51'(64'd1 << (TERM_W-1))))
      term_sat = {1'b1, {(TERM_W-1){1'b0}}};
    else
      term_sat = term_raw[TERM_W-1:0];
    sum_raw = 51'(acc) + 51'(term_sat);
    if (sum_raw > $signed(51'((64'd1 << (SUM_W-1)) - 64'd1)))
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    else if (sum_raw < -$signed(51'(64'd1 << (SUM_W-1))))
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    else
      sum_sat = sum_raw[SUM_W-1:0];
    if (neg)
      res = (qmag > DIV_NW'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(qmag[31:0]);
    else
      res = (qmag > DIV_NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qmag[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      var_reg   <= '0;
      acc       <= '0;
      div_go    <= 1'b0;
      pvalid    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            h   <= h_new;
            neg <= q_item.e[RET_W];
            ae  <= q_item.e[RET_W] ? RET_W'(-q_item.e) : q_item.e[RET_W-1:0];
            if (q_item.start) acc <= '0;
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          e2    <= ae * ae;
          norm  <= h;
          ncnt  <= '0;
          state <= S_NORM;
        end
        S_NORM: begin
          // shift up until the top bit is set
          if (norm[VAR_W-1]) begin
            x     <= norm[VAR_W-1 -: 32];
            frac  <= '0;
            lcnt  <= '0;
            state <= S_LOG;
          end else begin
            norm <= norm << 1;
            ncnt <= ncnt + 6'd1;
          end
        end
        S_LOG: begin
          if (sqx[63]) begin
            x    <= sqx[63:32];
            frac <= {frac[22:0], 1'b1};
          end else begin
            x    <= sqx[62:31];
            frac <= {frac[22:0], 1'b0};
          end
          lcnt <= lcnt + 5'd1;
          if (lcnt == 5'd23) state <= S_SCALE;
        end
        S_SCALE: begin
          p     <= 64'(lval * $signed({1'b0, LN2_Q32}));
          rad   <= {h, 16'd0};
          rr    <= '0;
          root  <= '0;
          rcnt  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rr   <= rr_nx;
          root <= root_nx;
          rad  <= rad << 2;
          rcnt <= rcnt + 5'd1;
          if (rcnt == 5'd31) begin
            div_go <= 1'b1;
            div_n  <= DIV_NW'({ae, 20'd0});
            div_d  <= DIV_DW'(root_nx);
            state  <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            qmag   <= div_q;
            div_go <= 1'b1;
            div_n  <= {1'b0, e2, 7'd0};
            div_d  <= h;
            state  <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            bval   <= (|div_q[DIV_NW-1:47]) ? (VAR_W'(1) << 47) : div_q[VAR_W-1:0];
            macc   <= 60'(cfg.omega);
            mcnt   <= '0;
            pvalid <= 1'b0;
            state  <= S_MAC;
          end
        end
        S_MAC: begin
          if (pvalid) macc <= macc + (pshift ? 60'(prod >> 32) : 60'(prod));
          if (mcnt != 3'd6) begin
            prod   <= op_a * op_b;
            pshift <= mcnt[0];
            pvalid <= 1'b1;
            mcnt   <= mcnt + 3'd1;
          end else begin
            pvalid <= 1'b0;
            if (pvalid) state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the result register to free up
          if (!out_valid || pop) begin
            cond_variance  <= h;
            std_residual   <= res;
            ll_term        <= term_sat;
            ll_sum         <= sum_sat;
            params_invalid <= cfg.invalid;
            out_valid      <= 1'b1;
            acc            <= sum_sat;
            var_reg        <= (|macc[59:VAR_W]) ? {VAR_W{1'b1}} : macc[VAR_W-1:0];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GJR_ASSERT(a_var_floor, out_valid |-> (cond_variance != '0), "zero variance reported")
  `GJR_ASSERT(a_div_phase, div_done |-> (state == S_DIVQ || state == S_DIVB), "stray divider result")
  `GJR_ASSERT(a_take_idle, q_take |=> (state == S_SQUARE), "item taken outside idle")
  `GJR_ASSERT(a_done_load, (state == S_DONE && (!out_valid || pop)) |=> out_valid, "result lost")
endmodule
`default_nettype wire

// File: hdl/gjr_garch_variance_filter.sv
// Top level: configuration registers, front end and back end of the filter
//
// Input channel: drive return_sample and start_series with push; a
// transaction completes when push is high and full is low. A two-entry
// queue holds demeaned samples, so up to two items are taken while the
// back end works.
// Result channel: while empty is low the oldest result is on
// cond_variance, std_residual, ll_term, ll_sum and params_invalid; it is
// taken when pop is high. A stalled result is held while the next item is
// already computed; the back end then waits until the result is popped.
// The back end works on one item at a time through its serial units:
// normalising the variance, 24 log squarings, 32 root steps, two
// divisions and a shared multiply-accumulate.
// Configuration: wr_en, wr_index, wr_data write one register per cycle;
// the user must write only while idle, which the block itself does not
// enforce; unknown indexes are dropped.
// Reset (rst, synchronous): clears queues, variance, sum and registers.
`timescale 1ns / 1ps
`default_nettype none
module gjr_garch_variance_filter
  import gjr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [RET_W-1:0]  return_sample,
  input  wire logic                     start_series,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [VAR_W-1:0]              cond_variance,
  output logic signed [31:0]            std_residual,
  output logic signed [TERM_W-1:0]      ll_term,
  output logic signed [SUM_W-1:0]       ll_sum,
  output logic                          params_invalid,
  input  wire logic                     wr_en,
  input  wire logic [2:0]               wr_index,
  input  wire logic [VAR_W-1:0]         wr_data
);
  logic signed [RET_W-1:0] mean;
  logic [VAR_W-1:0]        omega;
  logic [COEF_W-1:0]       alpha;
  logic [COEF_W-1:0]       gamma;
  logic [COEF_W-1:0]       beta;
  logic [VAR_W-1:0]        init_var;
  logic                    invalid;
  cfg_t                    cfg;
  logic [34:0]             stab_sum;
  logic                    q_valid;
  item_t                   q_item;
  logic                    q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean     <= '0;
      omega    <= '0;
      alpha    <= '0;
      gamma    <= '0;
      beta     <= '0;
      init_var <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MEAN:  mean     <= wr_data[RET_W-1:0];
        REG_OMEGA: omega    <= wr_data;
        REG_ALPHA: alpha    <= wr_data[COEF_W-1:0];
        REG_GAMMA: gamma    <= wr_data[COEF_W-1:0];
        REG_BETA:  beta     <= wr_data[COEF_W-1:0];
        REG_INIT:  init_var <= wr_data;
        default: ;
      endcase
    end
  end

  // stationarity check: 2*alpha + gamma + 2*beta against two
  assign stab_sum = {2'b0, alpha, 1'b0} + {3'b0, gamma} + {2'b0, beta, 1'b0};
  assign invalid  = (omega == '0) || stab_sum[34] || stab_sum[33];
  assign cfg      = {omega, alpha, gamma, beta, init_var, invalid};

  gjr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .return_sample (return_sample),
    .start_series  (start_series),
    .mean          (mean),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take)
  );

  gjr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take),
    .empty          (empty),
    .pop            (pop),
    .cond_variance  (cond_variance),
    .std_residual   (std_residual),
    .ll_term        (ll_term),
    .ll_sum         (ll_sum),
    .params_invalid (params_invalid)
  );
endmodule
`default_nettype wire

// File: test/tb_gjr_garch_variance_filter.sv
// Self-checking testbench for the GJR-GARCH(1,1) variance filter
`timescale 1ns / 1ps
`default_nettype none
module tb_gjr_garch_variance_filter;
  import gjr_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam longint LN2_FIX = 64'd2977044472;
  localparam longint HALF_LN_2PI = 60224;
  localparam longint TERM_HI = 64'sd549755813887;
  localparam longint SUM_HI = 64'sd140737488355327;

  typedef struct {
    logic [VAR_W-1:0]         cond_variance;
    logic signed [31:0]       std_residual;
    logic signed [TERM_W-1:0] ll_term;
    logic signed [SUM_W-1:0]  ll_sum;
    logic                     params_invalid;
  } filter_out_t;

  logic clk, rst;
  logic push, full, empty, pop;
  logic signed [RET_W-1:0] return_sample;
  logic start_series;
  logic [VAR_W-1:0] cond_variance;
  logic signed [31:0] std_residual;
  logic signed [TERM_W-1:0] ll_term;
  logic signed [SUM_W-1:0] ll_sum;
  logic params_invalid;
  logic wr_en;
  logic [2:0] wr_index;
  logic [VAR_W-1:0] wr_data;

  // shadow registers and filter state
  logic signed [31:0] mean_reg;
  logic [VAR_W-1:0] omega_reg, init_var_reg, var_state;
  logic [31:0] alpha_reg, gamma_reg, beta_reg;
  longint loglik_state;

  filter_out_t pending_results[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  gjr_garch_variance_filter DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .return_sample(return_sample), .start_series(start_series),
    .empty(empty), .pop(pop), .cond_variance(cond_variance),
    .std_residual(std_residual), .ll_term(ll_term), .ll_sum(ll_sum),
    .params_invalid(params_invalid), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // log2 in Q.24 by repeated squaring of the normalised mantissa
  function automatic longint log2_fix(logic [63:0] h);
    int n;
    logic [127:0] x;
    logic [63:0] frac;
    n = 0;
    frac = 0;
    while (n < 63 && (h >> (n + 1)) != 0) n++;
    if (n >= 31) x = h >> (n - 31);
    else x = h << (31 - n);
    for (int i = 0; i < 24; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= (128'd1 << 32)) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'(n) * 16777216 + longint'(frac);
  endfunction

  function automatic longint clamp_signed(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic filter_out_t garch_step(logic signed [31:0] ret, logic start);
    filter_out_t r;
    logic [63:0] h, ae, sroot, quot, pmag, q1, rem, bterm;
    logic [127:0] e2, e40, nv;
    longint e, resid, l, p, a, term, sum;
    logic neg;
    if (start) begin
      var_state = init_var_reg;
      loglik_state = 0;
    end
    h = (var_state == 0) ? 64'd1 : 64'(var_state);
    e = longint'(ret) - longint'(mean_reg);
    neg = e < 0;
    ae = neg ? 64'(-e) : 64'(e);
    e2 = 128'(ae) * 128'(ae);

    sroot = int_sqrt(h << 16);
    quot = (ae << 20) / sroot;
    if (neg) resid = (quot > 64'd2147483648) ? -longint'(64'd2147483648) : -longint'(quot);
    else resid = (quot > 64'd2147483647) ? longint'(64'd2147483647) : longint'(quot);

    l = log2_fix(h) - longint'(40) * 16777216;
    p = l * LN2_FIX;
    pmag = (p < 0) ? 64'(-p) : 64'(p);
    a = longint'(pmag >> 41);
    if (p < 0) a = -a;
    q1 = 64'(e2 / h);
    rem = 64'(e2 % h);
    if (q1 >= (64'd1 << 40)) bterm = 64'd1 << 47;
    else begin
      bterm = q1 * 128 + (rem * 128) / h;
      if (bterm > (64'd1 << 47)) bterm = 64'd1 << 47;
    end
    term = clamp_signed(-(HALF_LN_2PI + a + longint'(bterm)), TERM_HI);
    sum = clamp_signed(loglik_state + term, SUM_HI);
    loglik_state = sum;

    r.params_invalid = (omega_reg == 0) ||
        (2 * 128'(alpha_reg) + 128'(gamma_reg) + 2 * 128'(beta_reg) >= (128'd1 << 33));

    e40 = e2 >> 8;
    nv = 128'(omega_reg) + ((e40 * alpha_reg) >> 32) + ((128'(h) * beta_reg) >> 32);
    if (neg) nv = nv + ((e40 * gamma_reg) >> 32);
    var_state = (nv > 128'((64'd1 << 48) - 1)) ? '1 : nv[VAR_W-1:0];

    r.cond_variance = h[VAR_W-1:0];
    r.std_residual = resid[31:0];
    r.ll_term = term[TERM_W-1:0];
    r.ll_sum = sum[SUM_W-1:0];
    return r;
  endfunction

  task automatic send_sample(logic signed [31:0] ret, logic start);
    push <= 1'b1;
    return_sample <= ret;
    start_series <= start;
    do @(posedge clk); while (full);
    pending_results.push_back(garch_step(ret, start));
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // wait for every result, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold the write enable across back-to-back writes; end_writes drops it
  task automatic write_reg(logic [2:0] idx, logic [VAR_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_MEAN:  mean_reg = data[31:0];
      REG_OMEGA: omega_reg = data;
      REG_ALPHA: alpha_reg = data[31:0];
      REG_GAMMA: gamma_reg = data[31:0];
      REG_BETA:  beta_reg = data[31:0];
      REG_INIT:  init_var_reg = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    wr_en <= 1'b0;
  endtask

  task automatic write_all(logic signed [31:0] mean, logic [47:0] omega, logic [31:0] alpha,
                           logic [31:0] gamma, logic [31:0] beta, logic [47:0] init);
    write_reg(REG_MEAN, 48'(unsigned'(mean)));
    write_reg(REG_OMEGA, omega);
    write_reg(REG_ALPHA, 48'(alpha));
    write_reg(REG_GAMMA, 48'(gamma));
    write_reg(REG_BETA, 48'(beta));
    write_reg(REG_INIT, init);
    end_writes();
  endtask

  // registers at reset: invalid parameters and a zero variance
  task automatic test_reset_state();
    send_sample(32'sd0, 1'b0);
    send_sample(32'sh0100_0000, 1'b0);
    send_sample(-32'sh0100_0000, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    write_all(32'sd0, 48'h0000_0100_0000, 32'h0CCC_CCCD, 32'h1999_999A, 32'hE666_6666,
              48'h0100_0000_0000);
    send_sample(32'sd0, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'sh0080_0000, 1'b0);
    send_sample(-32'sh0080_0000, 1'b0);
    drain();
    write_all(32'h8000_0000, '1, '1, '1, '1, '1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    drain();
    write_all(32'h7FFF_FFFF, 48'd1, 32'd0, 32'd0, 32'd0, 48'd0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    drain();
  endtask

  // writes to unused indexes must be dropped
  task automatic test_spare_index();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 48'h5555_5555_5555);
    end_writes();
    send_sample(32'sh0123_4567, 1'b1);
    send_sample(-32'sh0123_4567, 1'b0);
    drain();
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  task automatic randomise_params();
    case ($urandom_range(9))
      0: write_all($urandom(), rand48(), $urandom(), $urandom(), $urandom(), rand48());
      1: write_all($urandom(), 48'd0, $urandom(), $urandom(), $urandom(), 48'd0);
      default: write_all($urandom_range(32'h0004_0000) - 32'h0002_0000,
                         48'($urandom_range(1, 32'h00FF_FFFF)),
                         $urandom_range(32'h2000_0000), $urandom_range(32'h2000_0000),
                         $urandom_range(32'hE000_0000, 32'h8000_0000),
                         48'({$urandom_range(32'h0004_0000), $urandom()}));
    endcase
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int n_items);
    logic signed [31:0] ret;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int chunk = 0; chunk < n_items / 100; chunk++) begin
      randomise_params();
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(9))
          0, 1: ret = $urandom();
          2: ret = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: ret = mean_reg + ($urandom_range(32'h0200_0000) - 32'h0100_0000);
        endcase
        send_sample(ret, (i == 0) || ($urandom_range(49) == 0));
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    pop <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
      end else begin
        filter_out_t want;
        want = pending_results.pop_front();
        if (cond_variance !== want.cond_variance) begin
          $error("cond_variance: expected %0h, got %0h", want.cond_variance, cond_variance);
          errors++;
        end
        if (std_residual !== want.std_residual) begin
          $error("std_residual: expected %0d, got %0d", want.std_residual, std_residual);
          errors++;
        end
        if (ll_term !== want.ll_term) begin
          $error("ll_term: expected %0d, got %0d", want.ll_term, ll_term);
          errors++;
        end
        if (ll_sum !== want.ll_sum) begin
          $error("ll_sum: expected %0d, got %0d", want.ll_sum, ll_sum);
          errors++;
        end
        if (params_invalid !== want.params_invalid) begin
          $error("params_invalid: expected %0b, got %0b", want.params_invalid,
                 params_invalid);
          errors++;
        end
      end
    end
  end

  // abort when no transaction completes for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_gjr_garch_variance_filter: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    return_sample = '0;
    start_series = 1'b0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    mean_reg = '0;
    omega_reg = '0;
    alpha_reg = '0;
    gamma_reg = '0;
    beta_reg = '0;
    init_var_reg = '0;
    var_state = '0;
    loglik_state = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_spare_index();
    test_random(29, 66, 400);
    test_random(66, 29, 400);
    test_random(0, 0, 400);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_gjr_garch_variance_filter: PASS");
    end else begin
      $display("tb_gjr_garch_variance_filter: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: gjr_garch_variance_filter.f
+incdir+hdl
hdl/gjr_pkg.sv
hdl/gjr_front.sv
hdl/gjr_divider.sv
hdl/gjr_back.sv
hdl/gjr_garch_variance_filter.sv
test/tb_gjr_garch_variance_filter.sv
